FILE: rtl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// LED priority ramp planner package
// Shared field widths, channel codes and the structs between the modules.
// ----------------------------------------------------------------------------
package lpr_pkg;

    // Field widths of the input and result items.
    localparam int COLOR_W   = 24;
    localparam int MS_W      = 16;
    localparam int SLOT_W    = 2;
    localparam int CH_W      = 2;
    localparam int LEVEL_W   = 8;
    localparam int IDX_W     = 6;
    localparam int DUTY_W    = 10;
    localparam int PLO_W     = 17;
    localparam int STEP_MS_W = 4;

    // Duty scale is 512, applied as a left shift of the level.
    localparam int DUTY_SHIFT = 9;

    // Shared divider sizes: dividend covers level * 512 and the on time,
    // divisor covers 255 * RAMP_STEPS at its largest.
    localparam int DIV_N_W   = LEVEL_W + DUTY_SHIFT;
    localparam int DIV_D_W   = 13;

    // Reciprocal scale: with a dividend below 2^17 and a divisor below 2^13,
    // a reciprocal rounded up at 2^30 gives the exact quotient.
    localparam int DIV_K     = 30;
    localparam int DIV_M_W   = 31;

    // Channel codes.
    localparam logic [CH_W-1:0] CH_BLUE  = 2'd0;
    localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_W-1:0] CH_RED   = 2'd2;

    // One stored light request.
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               flash_timed;
        logic [MS_W-1:0]    on_ms;
        logic [MS_W-1:0]    off_ms;
    } t_request;

    // Divider command and response.
    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
        logic [DIV_M_W-1:0] recip;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
        logic [DIV_D_W-1:0] remainder;
    } t_div_rsp;

endpackage

FILE: rtl/lpr_div.sv
// ----------------------------------------------------------------------------
// LPR shared divider
// Divides by a constant through reciprocal multiplication on one multiplier.
// ----------------------------------------------------------------------------
module lpr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpr_pkg::t_div_req i_req,
    output lpr_pkg::t_div_rsp o_rsp
);

    localparam int PROD_W = lpr_pkg::DIV_N_W + lpr_pkg::DIV_M_W;

    typedef enum logic [1:0] {
        P_IDLE,
        P_QUO,
        P_BACK,
        P_SUB
    } t_phase;

    t_phase                        r_phase;
    logic                          r_done;
    logic [lpr_pkg::DIV_N_W-1:0]   r_num;
    logic [lpr_pkg::DIV_N_W-1:0]   r_quo;
    logic [lpr_pkg::DIV_N_W-1:0]   r_back;
    logic [lpr_pkg::DIV_D_W-1:0]   r_dvr;
    logic [lpr_pkg::DIV_D_W-1:0]   r_rem;
    logic [lpr_pkg::DIV_M_W-1:0]   r_rcp;

    logic [lpr_pkg::DIV_N_W-1:0]   w_mul_a;
    logic [lpr_pkg::DIV_M_W-1:0]   w_mul_b;
    logic [PROD_W-1:0]             w_prod;

    // Shared multiplier: dividend times reciprocal, then quotient times divisor.
    always_comb begin
        if (r_phase == P_QUO) begin
            w_mul_a = r_num;
            w_mul_b = r_rcp;
        end else begin
            w_mul_a = r_quo;
            w_mul_b = {{(lpr_pkg::DIV_M_W - lpr_pkg::DIV_D_W){1'b0}}, r_dvr};
        end
        w_prod = {{lpr_pkg::DIV_M_W{1'b0}}, w_mul_a}
                 * {{lpr_pkg::DIV_N_W{1'b0}}, w_mul_b};
    end

    // Sequencer and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                P_IDLE: begin
                    if (i_req.start) begin
                        r_phase <= P_QUO;
                    end
                end
                P_QUO: begin
                    r_phase <= P_BACK;
                end
                P_BACK: begin
                    r_phase <= P_SUB;
                end
                P_SUB: begin
                    r_phase <= P_IDLE;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_phase <= P_IDLE;
                end
            endcase
        end
        if (r_phase == P_IDLE && i_req.start) begin
            r_num <= i_req.dividend;
            r_dvr <= i_req.divisor;
            r_rcp <= i_req.recip;
        end
        if (r_phase == P_QUO) begin
            r_quo <= w_prod[lpr_pkg::DIV_K +: lpr_pkg::DIV_N_W];
        end
        if (r_phase == P_BACK) begin
            r_back <= w_prod[lpr_pkg::DIV_N_W-1:0];
        end
        if (r_phase == P_SUB) begin
            r_rem <= lpr_pkg::DIV_D_W'(r_num - r_back);
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

FILE: rtl/lpr_slots.sv
// ----------------------------------------------------------------------------
// LPR request slots
// Holds the stored light requests and picks the winning one.
// ----------------------------------------------------------------------------
module lpr_slots #(
    parameter int SLOT_COUNT = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_we,
    input  logic [lpr_pkg::SLOT_W-1:0]  i_slot,
    input  lpr_pkg::t_request           i_req,
    output lpr_pkg::t_request           o_winner
);

    lpr_pkg::t_request r_req [SLOT_COUNT];

    // An item overwrites its slot; a slot beyond the count stores nothing.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!i_rst_n) begin
                r_req[i] <= '0;
            end else if (i_we && (int'(i_slot) == i)) begin
                r_req[i] <= i_req;
            end
        end
    end

    // Lowest slot with a lit color wins; slot 0 when all are dark.
    always_comb begin
        o_winner = r_req[0];
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_req[i].color != '0) begin
                o_winner = r_req[i];
            end
        end
    end

endmodule

FILE: rtl/led_priority_ramp_planner.sv
// ----------------------------------------------------------------------------
// LED priority ramp planner
// Stores light requests, picks the winner and emits LED channel writes.
// ----------------------------------------------------------------------------
// Flow: a steady item goes from select straight to its writes; a ramp item
// runs a duty divide on the shared divider ahead of each channel, and a short
// on time adds a step-time divide first. Output stalls hold the writes, and a
// new item is taken only once the last write of the previous one is accepted.
// Reset: synchronous active-low reset clears all stored requests to off.
module led_priority_ramp_planner #(
    parameter int RAMP_STEPS  = 16,
    parameter int MAX_STEP_MS = 15,
    parameter int SLOT_COUNT  = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [lpr_pkg::SLOT_W-1:0]        i_slot,
    input  logic [lpr_pkg::COLOR_W-1:0]       i_color,
    input  logic                              i_flash_timed,
    input  logic [lpr_pkg::MS_W-1:0]          i_on_ms,
    input  logic [lpr_pkg::MS_W-1:0]          i_off_ms,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [lpr_pkg::CH_W-1:0]          o_channel,
    output logic                              o_ramp_mode,
    output logic [lpr_pkg::LEVEL_W-1:0]       o_level,
    output logic [lpr_pkg::IDX_W-1:0]         o_table_index,
    output logic [lpr_pkg::DUTY_W-1:0]        o_duty,
    output logic signed [lpr_pkg::PLO_W-1:0]  o_pause_low,
    output logic [lpr_pkg::MS_W-1:0]          o_pause_high,
    output logic [lpr_pkg::STEP_MS_W-1:0]     o_step_ms,
    output logic                              o_last
);

    localparam int DUTY_DIV  = 255 * RAMP_STEPS;
    localparam int PAUSE_SUB = RAMP_STEPS * MAX_STEP_MS;
    localparam int I_W       = $clog2(RAMP_STEPS + 1);

    // Reciprocals of the two constant divisors, rounded up.
    localparam longint RECIP_ONE = longint'(1) << lpr_pkg::DIV_K;
    localparam logic [lpr_pkg::DIV_M_W-1:0] DUTY_RECIP = lpr_pkg::DIV_M_W'(
        (RECIP_ONE + longint'(DUTY_DIV) - 1) / longint'(DUTY_DIV));
    localparam logic [lpr_pkg::DIV_M_W-1:0] STEP_RECIP = lpr_pkg::DIV_M_W'(
        (RECIP_ONE + longint'(RAMP_STEPS) - 1) / longint'(RAMP_STEPS));

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEL,
        S_TDIV,
        S_CSTART,
        S_CDIV,
        S_EMIT,
        S_DRAIN
    } t_state;

    t_state r_state, n_state;

    lpr_pkg::t_request w_in_req;
    lpr_pkg::t_request w_winner;
    lpr_pkg::t_div_req w_div_req;
    lpr_pkg::t_div_rsp w_div_rsp;

    // Working registers.
    logic [lpr_pkg::COLOR_W-1:0]      r_color, n_color;
    logic                             r_timed, n_timed;
    logic [lpr_pkg::CH_W-1:0]         r_ch, n_ch;
    logic [I_W-1:0]                   r_i, n_i;
    logic [lpr_pkg::IDX_W-1:0]        r_idx, n_idx;
    logic [lpr_pkg::DUTY_W-1:0]       r_duty, n_duty;
    logic [lpr_pkg::DIV_D_W-1:0]      r_rem, n_rem;
    logic [lpr_pkg::DUTY_W-1:0]       r_q0, n_q0;
    logic [lpr_pkg::DIV_D_W-1:0]      r_r0, n_r0;
    logic signed [lpr_pkg::PLO_W-1:0] r_plo, n_plo;
    logic [lpr_pkg::MS_W-1:0]         r_phi, n_phi;
    logic [lpr_pkg::STEP_MS_W-1:0]    r_step, n_step;

    // Output register.
    logic                             r_ov, n_ov;
    logic [lpr_pkg::CH_W-1:0]         r_o_ch, n_o_ch;
    logic                             r_o_ramp, n_o_ramp;
    logic [lpr_pkg::LEVEL_W-1:0]      r_o_level, n_o_level;
    logic [lpr_pkg::IDX_W-1:0]        r_o_idx, n_o_idx;
    logic [lpr_pkg::DUTY_W-1:0]       r_o_duty, n_o_duty;
    logic signed [lpr_pkg::PLO_W-1:0] r_o_plo, n_o_plo;
    logic [lpr_pkg::MS_W-1:0]         r_o_phi, n_o_phi;
    logic [lpr_pkg::STEP_MS_W-1:0]    r_o_step, n_o_step;
    logic                             r_o_last, n_o_last;

    logic                             w_accept;
    logic                             w_win_timed;
    logic                             w_short_on;
    logic [lpr_pkg::LEVEL_W-1:0]      w_level;
    logic                             w_free;
    logic                             w_ch_end;
    logic                             w_item_end;
    logic [lpr_pkg::DIV_D_W:0]        w_rsum;
    logic                             w_carry;

    assign w_accept = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);

    assign w_in_req.color       = i_color;
    assign w_in_req.flash_timed = i_flash_timed;
    assign w_in_req.on_ms       = i_on_ms;
    assign w_in_req.off_ms      = i_off_ms;

    lpr_slots #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slots (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (w_accept),
        .i_slot   (i_slot),
        .i_req    (w_in_req),
        .o_winner (w_winner)
    );

    lpr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Winner classification for the ramp path.
    assign w_win_timed = w_winner.flash_timed && (w_winner.on_ms != '0)
                         && (w_winner.off_ms != '0);
    assign w_short_on  = ({1'b0, w_winner.on_ms} < (lpr_pkg::MS_W + 1)'(PAUSE_SUB));

    // Level of the current channel; green and blue are halved.
    always_comb begin
        unique case (r_ch)
            lpr_pkg::CH_BLUE:  w_level = {1'b0, r_color[7:1]};
            lpr_pkg::CH_GREEN: w_level = {1'b0, r_color[15:9]};
            default:           w_level = r_color[23:16];
        endcase
    end

    // Divider command: step time in the select state, duty base per channel.
    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.dividend = {w_level, {lpr_pkg::DUTY_SHIFT{1'b0}}};
        w_div_req.divisor  = lpr_pkg::DIV_D_W'(DUTY_DIV);
        w_div_req.recip    = DUTY_RECIP;
        if (r_state == S_SEL) begin
            w_div_req.start    = w_win_timed && w_short_on;
            w_div_req.dividend = lpr_pkg::DIV_N_W'(w_winner.on_ms);
            w_div_req.divisor  = lpr_pkg::DIV_D_W'(RAMP_STEPS);
            w_div_req.recip    = STEP_RECIP;
        end else if (r_state == S_CSTART) begin
            w_div_req.start = 1'b1;
        end
    end

    // Incremental duty: add the remainder, carry one when it wraps.
    assign w_rsum  = {1'b0, r_rem} + {1'b0, r_r0};
    assign w_carry = (w_rsum >= (lpr_pkg::DIV_D_W + 1)'(DUTY_DIV));

    assign w_free     = !r_ov || i_ready;
    assign w_ch_end   = !r_timed || (r_i == I_W'(RAMP_STEPS));
    assign w_item_end = w_ch_end && (r_ch == lpr_pkg::CH_RED);

    // Sequencer next state.
    always_comb begin
        n_state   = r_state;
        n_color   = r_color;
        n_timed   = r_timed;
        n_ch      = r_ch;
        n_i       = r_i;
        n_idx     = r_idx;
        n_duty    = r_duty;
        n_rem     = r_rem;
        n_q0      = r_q0;
        n_r0      = r_r0;
        n_plo     = r_plo;
        n_phi     = r_phi;
        n_step    = r_step;
        n_ov      = r_ov && !i_ready;
        n_o_ch    = r_o_ch;
        n_o_ramp  = r_o_ramp;
        n_o_level = r_o_level;
        n_o_idx   = r_o_idx;
        n_o_duty  = r_o_duty;
        n_o_plo   = r_o_plo;
        n_o_phi   = r_o_phi;
        n_o_step  = r_o_step;
        n_o_last  = r_o_last;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SEL;
                end
            end

            S_SEL: begin
                n_color = w_winner.color;
                n_timed = w_win_timed;
                n_ch    = lpr_pkg::CH_BLUE;
                n_idx   = '0;
                n_plo   = '0;
                n_phi   = '0;
                n_step  = '0;
                if (!w_win_timed) begin
                    n_state = S_EMIT;
                end else if (w_short_on) begin
                    n_plo   = lpr_pkg::PLO_W'(w_winner.off_ms);
                    n_state = S_TDIV;
                end else begin
                    n_step  = lpr_pkg::STEP_MS_W'(MAX_STEP_MS);
                    n_phi   = w_winner.on_ms - lpr_pkg::MS_W'(PAUSE_SUB);
                    n_plo   = lpr_pkg::PLO_W'(w_winner.off_ms)
                              - lpr_pkg::PLO_W'(PAUSE_SUB);
                    n_state = S_CSTART;
                end
            end

            S_TDIV: begin
                if (w_div_rsp.done) begin
                    n_step  = w_div_rsp.quotient[lpr_pkg::STEP_MS_W-1:0];
                    n_state = S_CSTART;
                end
            end

            S_CSTART: begin
                n_state = S_CDIV;
            end

            S_CDIV: begin
                if (w_div_rsp.done) begin
                    n_q0    = w_div_rsp.quotient[lpr_pkg::DUTY_W-1:0];
                    n_r0    = w_div_rsp.remainder;
                    n_duty  = '0;
                    n_rem   = '0;
                    n_i     = '0;
                    n_state = S_EMIT;
                end
            end

            S_EMIT: begin
                if (w_free) begin
                    n_ov      = 1'b1;
                    n_o_ch    = r_ch;
                    n_o_ramp  = r_timed;
                    n_o_level = w_level;
                    n_o_idx   = r_timed ? r_idx : '0;
                    n_o_duty  = r_timed ? r_duty : '0;
                    n_o_plo   = r_plo;
                    n_o_phi   = r_phi;
                    n_o_step  = r_step;
                    n_o_last  = w_item_end;
                    if (r_timed) begin
                        n_i   = r_i + 1'b1;
                        n_idx = r_idx + 1'b1;
                        if (w_carry) begin
                            n_rem  = lpr_pkg::DIV_D_W'(w_rsum
                                     - (lpr_pkg::DIV_D_W + 1)'(DUTY_DIV));
                            n_duty = r_duty + r_q0 + 1'b1;
                        end else begin
                            n_rem  = w_rsum[lpr_pkg::DIV_D_W-1:0];
                            n_duty = r_duty + r_q0;
                        end
                    end
                    if (w_item_end) begin
                        n_state = S_DRAIN;
                    end else if (w_ch_end) begin
                        n_ch    = r_ch + 1'b1;
                        n_state = r_timed ? S_CSTART : S_EMIT;
                    end
                end
            end

            S_DRAIN: begin
                if (w_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, control and payload registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_color   <= n_color;
        r_timed   <= n_timed;
        r_ch      <= n_ch;
        r_i       <= n_i;
        r_idx     <= n_idx;
        r_duty    <= n_duty;
        r_rem     <= n_rem;
        r_q0      <= n_q0;
        r_r0      <= n_r0;
        r_plo     <= n_plo;
        r_phi     <= n_phi;
        r_step    <= n_step;
        r_o_ch    <= n_o_ch;
        r_o_ramp  <= n_o_ramp;
        r_o_level <= n_o_level;
        r_o_idx   <= n_o_idx;
        r_o_duty  <= n_o_duty;
        r_o_plo   <= n_o_plo;
        r_o_phi   <= n_o_phi;
        r_o_step  <= n_o_step;
        r_o_last  <= n_o_last;
    end

    assign o_valid       = r_ov;
    assign o_channel     = r_o_ch;
    assign o_ramp_mode   = r_o_ramp;
    assign o_level       = r_o_level;
    assign o_table_index = r_o_idx;
    assign o_duty        = r_o_duty;
    assign o_pause_low   = r_o_plo;
    assign o_pause_high  = r_o_phi;
    assign o_step_ms     = r_o_step;
    assign o_last        = r_o_last;

endmodule

FILE: tb/tb_led_priority_ramp_planner.sv
// ----------------------------------------------------------------------------
// LED priority ramp planner testbench
// Sends light requests over the input channel and keeps its own copy of the
// stored requests. For each item it predicts the channel writes: the winner
// slot, the halved green and blue levels, and either three steady writes or
// the full ramp table with its duty and timing. Every write that leaves the
// block is compared field by field with the oldest prediction. Both sides
// idle at random, and one test holds the receiver off for a long stretch.
// ----------------------------------------------------------------------------
module tb_led_priority_ramp_planner;

    localparam int RAMP_STEPS     = 16;
    localparam int MAX_STEP_MS    = 15;
    localparam int SLOT_COUNT     = 3;
    localparam int DUTY_SCALE     = 512;
    localparam int FULL_LEVEL     = 255;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_ITEMS   = 190;

    // Request slot codes.
    localparam logic [lpr_pkg::SLOT_W-1:0] SLOT_ATTENTION = 2'd0;
    localparam logic [lpr_pkg::SLOT_W-1:0] SLOT_NOTIFY    = 2'd1;
    localparam logic [lpr_pkg::SLOT_W-1:0] SLOT_BATTERY   = 2'd2;
    localparam logic [lpr_pkg::SLOT_W-1:0] SLOT_UNUSED    = 2'd3;

    // One channel write as it leaves the block.
    typedef struct packed {
        logic [lpr_pkg::CH_W-1:0]      channel;
        logic                          ramp_mode;
        logic [lpr_pkg::LEVEL_W-1:0]   level;
        logic [lpr_pkg::IDX_W-1:0]     table_index;
        logic [lpr_pkg::DUTY_W-1:0]    duty;
        logic [lpr_pkg::PLO_W-1:0]     pause_low;
        logic [lpr_pkg::MS_W-1:0]      pause_high;
        logic [lpr_pkg::STEP_MS_W-1:0] step_ms;
        logic                          last;
    } t_led_write;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_ready;
    logic [lpr_pkg::SLOT_W-1:0]        i_slot;
    logic [lpr_pkg::COLOR_W-1:0]       i_color;
    logic                              i_flash_timed;
    logic [lpr_pkg::MS_W-1:0]          i_on_ms;
    logic [lpr_pkg::MS_W-1:0]          i_off_ms;
    logic                              o_valid;
    logic                              i_ready;
    logic [lpr_pkg::CH_W-1:0]          o_channel;
    logic                              o_ramp_mode;
    logic [lpr_pkg::LEVEL_W-1:0]       o_level;
    logic [lpr_pkg::IDX_W-1:0]         o_table_index;
    logic [lpr_pkg::DUTY_W-1:0]        o_duty;
    logic signed [lpr_pkg::PLO_W-1:0]  o_pause_low;
    logic [lpr_pkg::MS_W-1:0]          o_pause_high;
    logic [lpr_pkg::STEP_MS_W-1:0]     o_step_ms;
    logic                              o_last;

    // Predictor state and the writes still owed by the block.
    lpr_pkg::t_request stored_requests [SLOT_COUNT];
    t_led_write        expected_writes [$];

    int  mismatch_count    = 0;
    int  writes_checked    = 0;
    int  items_sent        = 0;
    int  ramp_items        = 0;
    int  steady_items      = 0;
    int  unused_slot_items = 0;
    int  idle_cycles       = 0;
    int  ready_hold_cycles = 0;
    bit  steady_flow       = 1'b0;

    led_priority_ramp_planner #(
        .RAMP_STEPS  (RAMP_STEPS),
        .MAX_STEP_MS (MAX_STEP_MS),
        .SLOT_COUNT  (SLOT_COUNT)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_slot        (i_slot),
        .i_color       (i_color),
        .i_flash_timed (i_flash_timed),
        .i_on_ms       (i_on_ms),
        .i_off_ms      (i_off_ms),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_channel     (o_channel),
        .o_ramp_mode   (o_ramp_mode),
        .o_level       (o_level),
        .o_table_index (o_table_index),
        .o_duty        (o_duty),
        .o_pause_low   (o_pause_low),
        .o_pause_high  (o_pause_high),
        .o_step_ms     (o_step_ms),
        .o_last        (o_last)
    );

    always #4 i_clk = ~i_clk;

    // Idle length: zero most of the time, a few short gaps, rarely a long one.
    function automatic int pick_gap(input int busy_pct);
        int roll;
        if (steady_flow) return 0;
        roll = $urandom_range(0, 99);
        if (roll >= busy_pct) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return $urandom_range(1, 3);
        if (roll < 93) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Update the stored requests and queue the writes this item causes.
    task automatic plan_led_writes(input logic [lpr_pkg::SLOT_W-1:0] slot,
                                   input logic [lpr_pkg::COLOR_W-1:0] color,
                                   input logic flash_timed,
                                   input logic [lpr_pkg::MS_W-1:0] on_ms,
                                   input logic [lpr_pkg::MS_W-1:0] off_ms);
        lpr_pkg::t_request           winner;
        t_led_write                  w;
        logic [lpr_pkg::LEVEL_W-1:0] lv [3];
        logic [lpr_pkg::CH_W-1:0]    ch_codes [3];
        bit                          found;
        int                          step_ms;
        int                          pause_high;
        int                          pause_low;
        int                          lvl;
        ch_codes[0] = lpr_pkg::CH_BLUE;
        ch_codes[1] = lpr_pkg::CH_GREEN;
        ch_codes[2] = lpr_pkg::CH_RED;
        if (slot < SLOT_COUNT) begin
            stored_requests[slot].color       = color;
            stored_requests[slot].flash_timed = flash_timed;
            stored_requests[slot].on_ms       = on_ms;
            stored_requests[slot].off_ms      = off_ms;
        end else begin
            unused_slot_items++;
        end

        // The first lit slot wins; with every slot dark, slot 0 still wins.
        winner = stored_requests[0];
        found  = 1'b0;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            if (!found && stored_requests[s].color != '0) begin
                winner = stored_requests[s];
                found  = 1'b1;
            end
        end
        lv[0] = winner.color[7:0] >> 1;
        lv[1] = winner.color[15:8] >> 1;
        lv[2] = winner.color[23:16];

        if (winner.flash_timed && winner.on_ms != '0 && winner.off_ms != '0) begin
            ramp_items++;
            // Short on times shrink the step; long ones keep it and pad pauses.
            if (MAX_STEP_MS * RAMP_STEPS > int'(winner.on_ms)) begin
                step_ms    = int'(winner.on_ms) / RAMP_STEPS;
                pause_high = 0;
                pause_low  = int'(winner.off_ms);
            end else begin
                step_ms    = MAX_STEP_MS;
                pause_high = int'(winner.on_ms) - RAMP_STEPS * MAX_STEP_MS;
                pause_low  = int'(winner.off_ms) - RAMP_STEPS * MAX_STEP_MS;
            end
            for (int ch = 0; ch < 3; ch++) begin
                for (int st = 0; st <= RAMP_STEPS; st++) begin
                    lvl           = int'(lv[ch]);
                    w.channel     = ch_codes[ch];
                    w.ramp_mode   = 1'b1;
                    w.level       = lv[ch];
                    w.table_index = lpr_pkg::IDX_W'(ch * (RAMP_STEPS + 1) + st);
                    w.duty        = lpr_pkg::DUTY_W'((st * DUTY_SCALE * lvl)
                                                     / (FULL_LEVEL * RAMP_STEPS));
                    w.pause_low   = pause_low[lpr_pkg::PLO_W-1:0];
                    w.pause_high  = pause_high[lpr_pkg::MS_W-1:0];
                    w.step_ms     = step_ms[lpr_pkg::STEP_MS_W-1:0];
                    w.last        = (ch == 2 && st == RAMP_STEPS);
                    expected_writes.insert(expected_writes.size(), w);
                end
            end
        end else begin
            steady_items++;
            for (int ch = 0; ch < 3; ch++) begin
                w           = '0;
                w.channel   = ch_codes[ch];
                w.level     = lv[ch];
                w.last      = (ch == 2);
                expected_writes.insert(expected_writes.size(), w);
            end
        end
    endtask

    // Offer one item after a random gap, wait until it is taken, then withdraw.
    task automatic send_request(input logic [lpr_pkg::SLOT_W-1:0] slot,
                                input logic [lpr_pkg::COLOR_W-1:0] color,
                                input logic flash_timed,
                                input logic [lpr_pkg::MS_W-1:0] on_ms,
                                input logic [lpr_pkg::MS_W-1:0] off_ms);
        int gap;
        gap = pick_gap(45);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_slot        <= slot;
        i_color       <= color;
        i_flash_timed <= flash_timed;
        i_on_ms       <= on_ms;
        i_off_ms      <= off_ms;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        plan_led_writes(slot, color, flash_timed, on_ms, off_ms);
        items_sent++;
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // Hold the sender until every predicted write has come out.
    task automatic wait_for_drain();
        while (expected_writes.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40) $display("MISMATCH: %s", msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("write %0d field %s: expected 0x%0h, got 0x%0h",
                                      writes_checked, name, want, got));
    endtask

    // Random field values, weighted toward the boundaries that matter.
    function automatic logic [lpr_pkg::COLOR_W-1:0] pick_color();
        case ($urandom_range(0, 7))
            0, 1:    return '0;
            2:       return lpr_pkg::COLOR_W'($urandom_range(1, 255)
                                              << (8 * $urandom_range(0, 2)));
            3:       return {{8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}},
                             {8{$urandom_range(0, 1) == 1}}};
            default: return lpr_pkg::COLOR_W'($urandom());
        endcase
    endfunction

    function automatic logic [lpr_pkg::MS_W-1:0] pick_on_time();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return lpr_pkg::MS_W'(RAMP_STEPS * MAX_STEP_MS - 1
                                           + $urandom_range(0, 2));
            2, 3, 4: return lpr_pkg::MS_W'($urandom_range(1, RAMP_STEPS * MAX_STEP_MS - 1));
            default: return lpr_pkg::MS_W'($urandom());
        endcase
    endfunction

    function automatic logic [lpr_pkg::MS_W-1:0] pick_off_time();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return lpr_pkg::MS_W'(RAMP_STEPS * MAX_STEP_MS);
            2, 3, 4: return lpr_pkg::MS_W'($urandom_range(1, RAMP_STEPS * MAX_STEP_MS - 1));
            default: return lpr_pkg::MS_W'($urandom());
        endcase
    endfunction

    // Lights off, full white, and timed flashing with a zero on or off time.
    task automatic test_steady_writes();
        send_request(SLOT_ATTENTION, 24'h000000, 1'b0, 16'd0, 16'd0);
        send_request(SLOT_ATTENTION, 24'hffffff, 1'b0, 16'hffff, 16'hffff);
        send_request(SLOT_ATTENTION, 24'h010101, 1'b1, 16'd0, 16'd500);
        send_request(SLOT_ATTENTION, 24'h808080, 1'b1, 16'd500, 16'd0);
        // A slot beyond the last one stores nothing but still plans writes.
        send_request(SLOT_UNUSED, 24'h123456, 1'b1, 16'd1000, 16'd1000);
    endtask

    // The lowest lit slot wins; all dark falls back to slot 0.
    task automatic test_slot_priority();
        send_request(SLOT_ATTENTION, 24'h000000, 1'b0, 16'd0, 16'd0);
        send_request(SLOT_BATTERY, 24'h00ff00, 1'b0, 16'd0, 16'd0);
        send_request(SLOT_NOTIFY, 24'h0000ff, 1'b1, 16'd300, 16'd300);
        send_request(SLOT_ATTENTION, 24'hff0000, 1'b0, 16'd0, 16'd0);
        send_request(SLOT_ATTENTION, 24'h000000, 1'b0, 16'd0, 16'd0);
        send_request(SLOT_NOTIFY, 24'h000000, 1'b1, 16'd300, 16'd300);
        send_request(SLOT_BATTERY, 24'h000000, 1'b1, 16'd100, 16'd100);
    endtask

    // Ramp timing around the short on time limit and a negative off pause.
    task automatic test_ramp_timing();
        send_request(SLOT_ATTENTION, 24'hffffff, 1'b1, 16'd1, 16'd1);
        send_request(SLOT_ATTENTION, 24'hffffff, 1'b1, 16'd239, 16'hffff);
        send_request(SLOT_ATTENTION, 24'h7f80fe, 1'b1, 16'd240, 16'd240);
        send_request(SLOT_ATTENTION, 24'ha5a5a5, 1'b1, 16'hffff, 16'd1);
        send_request(SLOT_ATTENTION, 24'h010203, 1'b1, 16'd241, 16'd239);
        send_request(SLOT_ATTENTION, 24'h000001, 1'b1, 16'd16, 16'hffff);
    endtask

    // The receiver stops for a long stretch while ramp and steady items keep coming.
    task automatic test_output_backpressure();
        steady_flow = 1'b1;
        @(posedge i_clk);
        ready_hold_cycles = HOLD_CYCLES;
        for (int n = 0; n < 8; n++) begin
            send_request(SLOT_ATTENTION, pick_color() | 24'h000100, n % 2 == 0,
                         16'd1 + lpr_pkg::MS_W'($urandom_range(0, 4000)),
                         16'd1 + lpr_pkg::MS_W'($urandom_range(0, 4000)));
        end
        steady_flow = 1'b0;
        wait_for_drain();
    endtask

    // Mostly valid slots with random content, some to the unused slot.
    task automatic test_random_requests();
        logic [lpr_pkg::SLOT_W-1:0] slot;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Alternate stretches with and without idling.
            if (n % 30 == 0) steady_flow = 1'b1;
            if (n % 30 == 12) steady_flow = 1'b0;
            if ($urandom_range(0, 9) == 0)
                slot = SLOT_UNUSED;
            else
                slot = lpr_pkg::SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
            send_request(slot, pick_color(), $urandom_range(0, 9) < 7,
                         pick_on_time(), pick_off_time());
            if (n % 45 == 44) wait_for_drain();
        end
        steady_flow = 1'b0;
    endtask

    // Receiver: random stalls, plus a long hold when a test asks for one.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        i_ready    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (ready_hold_cycles > 0) begin
                i_ready <= 1'b0;
                ready_hold_cycles--;
            end else if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                stall_left = pick_gap(30);
                if (stall_left > 0) begin
                    i_ready <= 1'b0;
                    stall_left--;
                end else begin
                    i_ready <= 1'b1;
                end
            end
        end
    end

    // Compare every accepted write with the oldest prediction.
    always @(posedge i_clk) begin : check_writes
        t_led_write want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (expected_writes.size() == 0) begin
                report_mismatch($sformatf("write on channel %0d with nothing expected",
                                          o_channel));
            end else begin
                want = expected_writes.pop_front();
                check_field("channel", o_channel, want.channel);
                check_field("ramp_mode", o_ramp_mode, want.ramp_mode);
                check_field("level", o_level, want.level);
                check_field("table_index", o_table_index, want.table_index);
                check_field("duty", o_duty, want.duty);
                check_field("pause_low", $unsigned(o_pause_low), want.pause_low);
                check_field("pause_high", o_pause_high, want.pause_high);
                check_field("step_ms", o_step_ms, want.step_ms);
                check_field("last", o_last, want.last);
                writes_checked++;
            end
        end
    end

    // Stop the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles, %0d writes outstanding.",
                     idle_cycles, expected_writes.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Main sequence.
    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_slot        = '0;
        i_color       = '0;
        i_flash_timed = 1'b0;
        i_on_ms       = '0;
        i_off_ms      = '0;
        for (int s = 0; s < SLOT_COUNT; s++) stored_requests[s] = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_steady_writes();
        test_slot_priority();
        test_ramp_timing();
        test_output_backpressure();
        test_random_requests();

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_writes.size() != 0)
            report_mismatch($sformatf("%0d writes never arrived", expected_writes.size()));

        $display("Sent %0d requests: %0d ramp plans, %0d steady plans, %0d to the unused slot.",
                 items_sent, ramp_items, steady_items, unused_slot_items);
        $display("Checked %0d channel writes, %0d mismatches.", writes_checked,
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
